### design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int ByteW     = 8;
    localparam int OpcodeW   = 4;
    localparam int KeptW     = 16;
    localparam int LenW      = 64;
    localparam int KeyW      = 32;
    localparam int IdxW      = KeptW + 1;
    localparam int CntW      = 4;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 16;
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [CfgIndexW-1:0] CfgLinkUp    = CfgIndexW'(0);
    localparam logic [CfgIndexW-1:0] CfgKeepLimit = CfgIndexW'(1);

    localparam logic [KeptW-1:0] KeepLimitReset = KeptW'(4095);

    localparam logic [6:0] Len7Ext16 = 7'd126;
    localparam logic [6:0] Len7Ext64 = 7'd127;
    localparam logic [CntW-1:0] Ext16Bytes = CntW'(2);
    localparam logic [CntW-1:0] Ext64Bytes = CntW'(8);
    localparam logic [CntW-1:0] KeyBytes   = CntW'(4);

    // one classified item between the front and back parts
    typedef struct packed {
        logic [ByteW-1:0]   raw;
        logic [ByteW-1:0]   key;
        logic               has_data;
        logic [OpcodeW-1:0] opcode;
        logic               last;
        logic [KeptW-1:0]   kept;
    } wsd_item_t;

endpackage

### design/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// header parser: tracks frame phase, length, mask key and payload position,
// and classifies each byte taken while the link is up; kept payload bytes and frame ends become a queued item
// ----------------------------------------------------------------------------
module wsd_front
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [ByteW-1:0] in_byte,
    input  logic             link_up,
    input  logic [KeptW-1:0] keep_limit,
    output logic             push,
    output wsd_item_t        push_item
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [OpcodeW-1:0] opcode_reg, opcode_next;
    logic               mask_reg, mask_next;
    logic [LenW-1:0]    len_reg, len_next;
    logic [KeyW-1:0]    key_reg, key_next;
    logic [LenW-1:0]    rem_reg, rem_next;
    logic [IdxW-1:0]    idx_reg, idx_next;

    logic               len_done;
    logic               hdr_end;
    logic [LenW-1:0]    hdr_len;
    logic               pay_last;
    logic [ByteW-1:0]   key_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        len_done    = 1'b0;
        hdr_end     = 1'b0;
        hdr_len     = len_reg;
        pay_last    = (rem_reg == LenW'(1));
        key_byte    = key_reg[KeyW-1-ByteW*idx_reg[1:0] -: ByteW];
        push        = 1'b0;
        push_item   = '{raw: '0, key: '0, has_data: 1'b0, opcode: opcode_reg,
                        last: 1'b1, kept: '0};

        if (take && link_up)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = in_byte[7];
                    key_next  = '0;
                    if (in_byte[6:0] == Len7Ext16 || in_byte[6:0] == Len7Ext64)
                    begin
                        len_next   = '0;
                        cnt_next   = (in_byte[6:0] == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        len_next = LenW'(in_byte[6:0]);
                        len_done = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    len_next = {len_reg[LenW-ByteW-1:0], in_byte};
                    cnt_next = cnt_reg - CntW'(1);
                    len_done = (cnt_next == '0);
                end
                PH_MASK:
                begin
                    key_next = {key_reg[KeyW-ByteW-1:0], in_byte};
                    cnt_next = cnt_reg - CntW'(1);
                    hdr_end  = (cnt_next == '0);
                end
                PH_PAY:
                begin
                    if (idx_reg < {1'b0, keep_limit})
                    begin
                        push      = 1'b1;
                        push_item = '{raw: in_byte, key: key_byte, has_data: 1'b1,
                                      opcode: opcode_reg, last: pay_last,
                                      kept: idx_reg[KeptW-1:0] + KeptW'(1)};
                    end
                    else if (pay_last)
                    begin
                        push           = 1'b1;
                        push_item.kept = keep_limit;
                    end
                    rem_next = rem_reg - LenW'(1);
                    idx_next = idx_reg[IdxW-1] ? idx_reg : idx_reg + IdxW'(1);
                    if (pay_last)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    opcode_next = in_byte[OpcodeW-1:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            if (len_done)
            begin
                if (mask_next)
                begin
                    cnt_next   = KeyBytes;
                    phase_next = PH_MASK;
                end
                else
                begin
                    hdr_end = 1'b1;
                end
            end

            if (hdr_end)
            begin
                hdr_len  = len_next;
                idx_next = '0;
                rem_next = hdr_len;
                if (hdr_len == '0)
                begin
                    phase_next = PH_HDR0;
                    push       = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= '0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            len_reg    <= '0;
            key_reg    <= '0;
            rem_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

### design/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// short item queue between the parser and the output stage
// ----------------------------------------------------------------------------
module wsd_queue
    import wsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  wsd_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output wsd_item_t head_item
);

    wsd_item_t             slot_reg [QueueDepth];
    logic [QueuePtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0]  count_reg, count_next;

    assign full      = (count_reg == QueueCntW'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QueuePtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + QueueCntW'(push) - QueueCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// output stage: unmasks payload bytes and holds the result item
// ----------------------------------------------------------------------------
module wsd_back
    import wsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  wsd_item_t          q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ByteW-1:0]   data_byte,
    output logic               has_data,
    output logic [OpcodeW-1:0] frame_opcode,
    output logic               frame_last,
    output logic [KeptW-1:0]   kept_count
);

    logic               valid_reg, valid_next;
    logic [ByteW-1:0]   data_reg;
    logic               has_reg;
    logic [OpcodeW-1:0] opcode_reg;
    logic               last_reg;
    logic [KeptW-1:0]   kept_reg;

    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg   <= q_item.has_data ? (q_item.raw ^ q_item.key) : '0;
            has_reg    <= q_item.has_data;
            opcode_reg <= q_item.opcode;
            last_reg   <= q_item.last;
            kept_reg   <= q_item.kept;
        end
    end

    assign out_valid    = valid_reg;
    assign data_byte    = data_reg;
    assign has_data     = has_reg;
    assign frame_opcode = opcode_reg;
    assign frame_last   = last_reg;
    assign kept_count   = kept_reg;

endmodule

### design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser, one stream byte per item
// ----------------------------------------------------------------------------
// Takes one byte per cycle and returns zero or one result item for it: each
// kept payload byte unmasked, plus a data-less end marker for an empty frame
// or a frame whose tail went past keep_limit. The header parser decides each
// byte's role in the same cycle it is taken; a two-item queue and a registered
// output stage follow, so a stalled output fills the queue before in_ready
// drops. A result is registered in a queue slot and then in the output stage
// before it is presented on the output.
// Configuration writes are taken at any time (cfg_ready is always high).
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ByteW-1:0]     in_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ByteW-1:0]     data_byte,
    output logic                 has_data,
    output logic [OpcodeW-1:0]   frame_opcode,
    output logic                 frame_last,
    output logic [KeptW-1:0]     kept_count
);

    logic             link_up_reg;
    logic [KeptW-1:0] keep_limit_reg;
    logic             take;
    logic             push;
    wsd_item_t        push_item;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    wsd_item_t        q_item;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign take      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg    <= 1'b0;
            keep_limit_reg <= KeepLimitReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CfgLinkUp:    link_up_reg    <= cfg_data[0];
                CfgKeepLimit: keep_limit_reg <= cfg_data[KeptW-1:0];
                default:      ;
            endcase
        end
    end

    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .in_byte    (in_byte),
        .link_up    (link_up_reg),
        .keep_limit (keep_limit_reg),
        .push       (push),
        .push_item  (push_item)
    );

    wsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (q_item)
    );

    wsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .has_data     (has_data),
        .frame_opcode (frame_opcode),
        .frame_last   (frame_last),
        .kept_count   (kept_count)
    );

    // an item is only queued for a byte taken while the link is up
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (take && link_up_reg))
        else $error("item queued without an accepted byte");

    // an end marker is always the final result of its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_data) |-> frame_last)
        else $error("end marker not flagged as last");

    // a payload byte always counts itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_data) |-> (kept_count != '0))
        else $error("payload item with zero kept count");

endmodule
